// File: sv/active_expired_priority_queue_defines.svh
// Assertion macros used by the checker file of the run queue block.
// No dependencies.
`ifndef ACTIVE_EXPIRED_PRIORITY_QUEUE_DEFINES_SVH
`define ACTIVE_EXPIRED_PRIORITY_QUEUE_DEFINES_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define APQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define APQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/apq_pkg.sv
// Package of the active/expired run queue: sizes, entry and control types, codes.
// No dependencies.
package apq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PRIO_LEVELS = 4;
   localparam int ID_WIDTH = 8;

   localparam int PRIO_W = $clog2(PRIO_LEVELS);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_FIELD_W = 8;
   localparam int PRIO_FIELD_W = 2;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_TAKE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic pop;
      logic load_pop;
      logic clear;
   } row_ctrl_type;

endpackage

// File: sv/active_expired_priority_queue.sv
// Active/expired priority run queue: two sorted slot chains and a registered result beat.
// The result beat is registered and appears in the cycle after the request beat is accepted.
// Throughput: one request per cycle if not stalled; every slot compares and shifts at once.
// Reset: synchronous, active high; both queues empty and no result pending.
// Queue contents are not cleared by reset; only the fill counts and result valid are.
// Depends on apq_pkg, apq_row and apq_cell.
module active_expired_priority_queue import apq_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,    // proc_id[7:0], dyn_prio[9:8], expired[10], zero
   input logic req_tuser,                     // action
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_id[7:0], out_prio[9:8], zero
   output logic [STATUS_W-1:0] rsp_tuser      // status
);

   logic accept;
   logic is_take;
   logic to_expired;
   logic [ID_FIELD_W-1:0] proc_id;
   logic [PRIO_FIELD_W-1:0] dyn_prio;
   entry_type new_entry;

   entry_type act_entries [QUEUE_DEPTH];
   entry_type exp_entries [QUEUE_DEPTH];
   logic [CNT_W-1:0] act_count;
   logic [CNT_W-1:0] exp_count;
   row_ctrl_type act_ctrl;
   row_ctrl_type exp_ctrl;
   logic act_full;
   logic exp_full;

   logic rsp_tvalid_ff;
   logic rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_in;
   status_type status_ff;
   status_type status_in;
   entry_type head;

   assign proc_id = req_tdata[ID_FIELD_W-1:0];
   assign dyn_prio = req_tdata[ID_FIELD_W+PRIO_FIELD_W-1:ID_FIELD_W];
   assign to_expired = req_tdata[ID_FIELD_W+PRIO_FIELD_W];
   assign is_take = (req_tuser == ACT_TAKE);

   assign new_entry.id = ID_WIDTH'(proc_id);
   assign new_entry.prio = (int'(dyn_prio) >= PRIO_LEVELS) ? PRIO_W'(PRIO_LEVELS - 1)
                                                           : PRIO_W'(dyn_prio);

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;

   assign act_full = (act_count == CNT_W'(QUEUE_DEPTH));
   assign exp_full = (exp_count == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      act_ctrl = '0;
      exp_ctrl = '0;
      if (accept) begin
         if (!is_take) begin
            act_ctrl.ins = !to_expired && !act_full;
            exp_ctrl.ins = to_expired && !exp_full;
         end else if (act_count != '0) begin
            act_ctrl.pop = 1'b1;
         end else if (exp_count != '0) begin
            act_ctrl.load_pop = 1'b1;
            exp_ctrl.clear = 1'b1;
         end
      end
   end

   apq_row u_active (
      .clock (clock),
      .reset (reset),
      .ctrl (act_ctrl),
      .new_entry (new_entry),
      .other_entries (exp_entries),
      .other_count (exp_count),
      .entries (act_entries),
      .count (act_count)
   );

   apq_row u_expired (
      .clock (clock),
      .reset (reset),
      .ctrl (exp_ctrl),
      .new_entry (new_entry),
      .other_entries (act_entries),
      .other_count (act_count),
      .entries (exp_entries),
      .count (exp_count)
   );

   assign head = (act_count != '0) ? act_entries[0] : exp_entries[0];

   always_comb begin
      status_in = ST_OK;
      rsp_tdata_in = '0;
      if (!is_take) begin
         if ((to_expired && exp_full) || (!to_expired && act_full)) begin
            status_in = ST_FULL;
         end
      end else if (act_count == '0 && exp_count == '0) begin
         status_in = ST_EMPTY;
      end else begin
         rsp_tdata_in = RSP_DATA_W'({PRIO_FIELD_W'(head.prio), ID_FIELD_W'(head.id)});
      end
   end

   assign rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = status_ff;

endmodule

// File: sv/apq_cell.sv
// One queue slot: holds an entry and moves it left, right or in from the other row.
// Depends on apq_pkg.
module apq_cell import apq_pkg::*; (
   input logic clock,
   input row_ctrl_type ctrl,
   input logic valid,
   input entry_type new_entry,
   input entry_type left_entry,
   input logic left_stays,
   input entry_type right_entry,
   input entry_type other_right_entry,
   output entry_type entry,
   output logic stays
);

   entry_type entry_ff;
   entry_type entry_in;

   assign stays = valid && (entry_ff.prio >= new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (!stays) begin
            entry_in = left_stays ? new_entry : left_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end else if (ctrl.load_pop) begin
         entry_in = other_right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: sv/apq_row.sv
// One sorted run queue built as a chain of slots plus its fill count.
// Depends on apq_pkg and apq_cell.
module apq_row import apq_pkg::*; (
   input logic clock,
   input logic reset,
   input row_ctrl_type ctrl,
   input entry_type new_entry,
   input entry_type other_entries [QUEUE_DEPTH],
   input logic [CNT_W-1:0] other_count,
   output entry_type entries [QUEUE_DEPTH],
   output logic [CNT_W-1:0] count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic stays [QUEUE_DEPTH];

   assign count = count_ff;

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      logic valid;
      entry_type left_entry;
      logic left_stays;
      entry_type right_entry;
      entry_type other_right_entry;

      assign valid = CNT_W'(k) < count_ff;

      if (k == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_stays = 1'b1;
      end else begin : g_inner
         assign left_entry = entries[k-1];
         assign left_stays = stays[k-1];
      end

      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = entries[k];
         assign other_right_entry = other_entries[k];
      end else begin : g_body
         assign right_entry = entries[k+1];
         assign other_right_entry = other_entries[k+1];
      end

      apq_cell u_cell (
         .clock (clock),
         .ctrl (ctrl),
         .valid (valid),
         .new_entry (new_entry),
         .left_entry (left_entry),
         .left_stays (left_stays),
         .right_entry (right_entry),
         .other_right_entry (other_right_entry),
         .entry (entries[k]),
         .stays (stays[k])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end else if (ctrl.load_pop) begin
         count_in = other_count - 1'b1;
      end else if (ctrl.clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: sv/apq_checker.sv
// Port-level checker for the run queue block and its bind to the top level.
// Depends on apq_pkg and active_expired_priority_queue_defines.svh.
`include "active_expired_priority_queue_defines.svh"

module apq_checker import apq_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);

   `APQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled result beat changed.")
   `APQ_ASSERT_NEXT(a_rsp_follows, req_tvalid && req_tready, rsp_tvalid, "Accepted request beat gave no result beat.")
   `APQ_ASSERT_NEXT(a_no_spurious, !(req_tvalid && req_tready) && (!rsp_tvalid || rsp_tready), !rsp_tvalid, "Result beat without a request beat.")
   `APQ_ASSERT_SAME(a_error_zero, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata == '0, "Error result beat carries data.")

endmodule

bind active_expired_priority_queue apq_checker u_apq_checker (.*);
